// File: rtl/wgcp_pkg.sv
// shared types and constants for the world to grid cell projection
package wgcp_pkg;

    localparam int WORD_W    = 32;
    localparam int LAYER_W   = 8;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int COEF_FRAC = 24;
    localparam int CELL_FRAC = 16;
    localparam int TERM_W    = PROD_W - COEF_FRAC;
    localparam int PAIR_W    = TERM_W + 1;
    localparam int SUM_W     = TERM_W + 2;
    localparam int CELL_W    = SUM_W - CELL_FRAC;
    localparam int CX_W      = 6;
    localparam int CY_W      = 6;
    localparam int CZ_W      = 4;

    localparam logic [IDX_W-1:0] REG_COEF_XX       = 4'd0;
    localparam logic [IDX_W-1:0] REG_COEF_XY       = 4'd1;
    localparam logic [IDX_W-1:0] REG_COEF_YX       = 4'd2;
    localparam logic [IDX_W-1:0] REG_COEF_YY       = 4'd3;
    localparam logic [IDX_W-1:0] REG_OFFSET_X      = 4'd4;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y      = 4'd5;
    localparam logic [IDX_W-1:0] REG_LAYER_SHIFT_X = 4'd6;
    localparam logic [IDX_W-1:0] REG_LAYER_SHIFT_Y = 4'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] coef_xx;
        logic signed [WORD_W-1:0] coef_xy;
        logic signed [WORD_W-1:0] coef_yx;
        logic signed [WORD_W-1:0] coef_yy;
        logic signed [WORD_W-1:0] offset_x;
        logic signed [WORD_W-1:0] offset_y;
        logic signed [WORD_W-1:0] layer_shift_x;
        logic signed [WORD_W-1:0] layer_shift_y;
    } cfg_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctl_t;

endpackage

// File: rtl/wgcp_cfg.sv
// configuration register file
module wgcp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wgcp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [wgcp_pkg::WORD_W-1:0]   cfg_data,
    output wgcp_pkg::cfg_t                cfg
);
    import wgcp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_XX:       cfg_next.coef_xx       = cfg_data;
                REG_COEF_XY:       cfg_next.coef_xy       = cfg_data;
                REG_COEF_YX:       cfg_next.coef_yx       = cfg_data;
                REG_COEF_YY:       cfg_next.coef_yy       = cfg_data;
                REG_OFFSET_X:      cfg_next.offset_x      = cfg_data;
                REG_OFFSET_Y:      cfg_next.offset_y      = cfg_data;
                REG_LAYER_SHIFT_X: cfg_next.layer_shift_x = cfg_data;
                REG_LAYER_SHIFT_Y: cfg_next.layer_shift_y = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/wgcp_axis.sv
// three-stage datapath for one projected axis: products, pair sums, floored cell
module wgcp_axis (
    input  logic                                clk,
    input  wgcp_pkg::pipe_ctl_t                 ctl,
    input  logic signed [wgcp_pkg::WORD_W-1:0]  world_x,
    input  logic signed [wgcp_pkg::WORD_W-1:0]  world_y,
    input  logic signed [wgcp_pkg::LAYER_W-1:0] layer,
    input  logic signed [wgcp_pkg::WORD_W-1:0]  coef_a,
    input  logic signed [wgcp_pkg::WORD_W-1:0]  coef_b,
    input  logic signed [wgcp_pkg::WORD_W-1:0]  offset,
    input  logic signed [wgcp_pkg::WORD_W-1:0]  shift,
    output logic signed [wgcp_pkg::CELL_W-1:0]  cell_pos
);
    import wgcp_pkg::*;

    logic signed [PROD_W-1:0] pa_reg, pa_next;
    logic signed [PROD_W-1:0] pb_reg, pb_next;
    logic signed [TERM_W-1:0] pl_reg, pl_next;
    logic signed [TERM_W-1:0] ta, tb;
    logic signed [PAIR_W-1:0] sab_reg, sab_next;
    logic signed [PAIR_W-1:0] sol_reg, sol_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [CELL_W-1:0] cell_reg, cell_next;

    // stage 1: exact products
    always_comb
    begin
        pa_next = PROD_W'(coef_a) * PROD_W'(world_x);
        pb_next = PROD_W'(coef_b) * PROD_W'(world_y);
        pl_next = TERM_W'(layer) * TERM_W'(shift);
    end

    // stage 2: floor the Q.40 products to Q24.16 and add in pairs
    always_comb
    begin
        ta       = $signed(pa_reg[PROD_W-1:COEF_FRAC]);
        tb       = $signed(pb_reg[PROD_W-1:COEF_FRAC]);
        sab_next = PAIR_W'(ta) + PAIR_W'(tb);
        sol_next = PAIR_W'(offset) + PAIR_W'(pl_reg);
    end

    // stage 3: final add, floor to whole cells
    always_comb
    begin
        sum       = SUM_W'(sab_reg) + SUM_W'(sol_reg);
        cell_next = $signed(sum[SUM_W-1:CELL_FRAC]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pl_reg <= pl_next;
        end
        if (ctl.en2)
        begin
            sab_reg <= sab_next;
            sol_reg <= sol_next;
        end
        if (ctl.en3)
            cell_reg <= cell_next;
    end

    assign cell_pos = cell_reg;

endmodule

// File: rtl/world_to_grid_cell_projection.sv
// top level: world point to grid cell projection pipeline
//
//  channel  | valid     | stall      | payload
//  ---------+-----------+------------+---------------------------------
//  query    | in_valid  | in_stall   | world_x, world_y, layer
//  result   | out_valid | out_stall  | hit, cell_x, cell_y, cell_z
//  config   | cfg_we    | (none)     | cfg_index, cfg_data
//
// four register stages: products, pair sums, floored cells, bounds check
// one query per cycle while out_stall is low; out_valid is the last stage's valid bit
// each stage has its own valid bit and loads when empty or when the next one moves,
// so a stalled result holds while the earlier stages keep filling bubbles
// reset clears the valid bits and the configuration registers only
module world_to_grid_cell_projection #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_DEPTH  = 64,
    parameter int GRID_HEIGHT = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wgcp_pkg::IDX_W-1:0]           cfg_index,
    input  logic [wgcp_pkg::WORD_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [wgcp_pkg::WORD_W-1:0]   world_x,
    input  logic signed [wgcp_pkg::WORD_W-1:0]   world_y,
    input  logic signed [wgcp_pkg::LAYER_W-1:0]  layer,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic [wgcp_pkg::CX_W-1:0]            cell_x,
    output logic [wgcp_pkg::CY_W-1:0]            cell_y,
    output logic [wgcp_pkg::CZ_W-1:0]            cell_z
);
    import wgcp_pkg::*;

    localparam logic [CELL_W-2:0]  LIM_X = (CELL_W-1)'(GRID_WIDTH);
    localparam logic [CELL_W-2:0]  LIM_Y = (CELL_W-1)'(GRID_DEPTH);
    localparam logic [LAYER_W-1:0] LIM_Z = LAYER_W'(GRID_HEIGHT);

    cfg_t       cfg;
    pipe_ctl_t  ctl;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [LAYER_W-1:0] lay1_reg, lay2_reg, lay3_reg;
    logic signed [CELL_W-1:0]  cx, cy;

    logic              hit_reg, hit_next;
    logic [CX_W-1:0]   cx_reg, cx_next;
    logic [CY_W-1:0]   cy_reg, cy_next;
    logic [CZ_W-1:0]   cz_reg, cz_next;
    logic              in_x, in_y, in_z;

    wgcp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ready ripples back from the output register
    always_comb
    begin
        rdy4     = !v4_reg || !out_stall;
        rdy3     = !v3_reg || rdy4;
        rdy2     = !v2_reg || rdy3;
        rdy1     = !v1_reg || rdy2;
        ctl.en1  = rdy1;
        ctl.en2  = rdy2;
        ctl.en3  = rdy3;
        in_stall = !rdy1;
    end

    wgcp_axis u_axis_x (
        .clk      (clk),
        .ctl      (ctl),
        .world_x  (world_x),
        .world_y  (world_y),
        .layer    (layer),
        .coef_a   (cfg.coef_xx),
        .coef_b   (cfg.coef_xy),
        .offset   (cfg.offset_x),
        .shift    (cfg.layer_shift_x),
        .cell_pos (cx)
    );

    wgcp_axis u_axis_y (
        .clk      (clk),
        .ctl      (ctl),
        .world_x  (world_x),
        .world_y  (world_y),
        .layer    (layer),
        .coef_a   (cfg.coef_yx),
        .coef_b   (cfg.coef_yy),
        .offset   (cfg.offset_y),
        .shift    (cfg.layer_shift_y),
        .cell_pos (cy)
    );

    // bounds check; a negative cell fails on its sign bit
    always_comb
    begin
        in_x     = !cx[CELL_W-1] && (cx[CELL_W-2:0] < LIM_X);
        in_y     = !cy[CELL_W-1] && (cy[CELL_W-2:0] < LIM_Y);
        in_z     = !lay3_reg[LAYER_W-1] &&
                   ({1'b0, lay3_reg[LAYER_W-2:0]} < LIM_Z);
        hit_next = in_x && in_y && in_z;
        cx_next  = hit_next ? cx[CX_W-1:0] : '0;
        cy_next  = hit_next ? cy[CY_W-1:0] : '0;
        cz_next  = hit_next ? lay3_reg[CZ_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            lay1_reg <= layer;
        if (rdy2)
            lay2_reg <= lay1_reg;
        if (rdy3)
            lay3_reg <= lay2_reg;
        if (rdy4)
        begin
            hit_reg <= hit_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            cz_reg  <= cz_next;
        end
    end

    assign out_valid = v4_reg;
    assign hit       = hit_reg;
    assign cell_x    = cx_reg;
    assign cell_y    = cy_reg;
    assign cell_z    = cz_reg;

endmodule

// File: verif/world_to_grid_cell_projection_tb.sv
// self-checking testbench for the world to grid cell projection pipeline
`timescale 1ns / 1ps

module world_to_grid_cell_projection_tb;

    import wgcp_pkg::*;

    localparam int GRID_W = 64;
    localparam int GRID_D = 64;
    localparam int GRID_H = 16;

    localparam int NUM_CFG_REGS   = 8;
    localparam int TARGET_QUERIES = 1550;
    localparam int LONG_HOLD      = 120;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STUCK_LIMIT    = 2000;

    localparam int ONE_CELL = 1 << CELL_FRAC;
    localparam int ONE_COEF = 1 << COEF_FRAC;
    localparam int WORD_MAX = 32'sh7FFF_FFFF;
    localparam int WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0]  wx;
        logic signed [WORD_W-1:0]  wy;
        logic signed [LAYER_W-1:0] lay;
    } query_t;

    typedef struct packed {
        logic            hit;
        logic [CX_W-1:0] x;
        logic [CY_W-1:0] y;
        logic [CZ_W-1:0] z;
    } cell_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [IDX_W-1:0]           cfg_index = '0;
    logic [WORD_W-1:0]          cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [WORD_W-1:0]   world_x   = '0;
    logic signed [WORD_W-1:0]   world_y   = '0;
    logic signed [LAYER_W-1:0]  layer     = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       hit;
    logic [CX_W-1:0]            cell_x;
    logic [CY_W-1:0]            cell_y;
    logic [CZ_W-1:0]            cell_z;

    query_t pending_queries [$];
    cell_t  expected_cells [$];
    int     cfg_shadow [NUM_CFG_REGS];
    int     mismatch_count = 0;
    int     query_total    = 0;
    int     hold_requests  = 0;

    world_to_grid_cell_projection #(
        .GRID_WIDTH  (GRID_W),
        .GRID_DEPTH  (GRID_D),
        .GRID_HEIGHT (GRID_H)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .world_x   (world_x),
        .world_y   (world_y),
        .layer     (layer),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .cell_z    (cell_z)
    );

    always #2 clk = ~clk;

    // one axis: two floored Q.40 products, offset and layer step, then floor to a cell
    function automatic longint axis_cell(int coef_a, int coef_b, int offset, int step,
                                         int wx, int wy, byte lay);
        longint acc;
        acc = ((longint'(coef_a) * longint'(wx)) >>> COEF_FRAC)
            + ((longint'(coef_b) * longint'(wy)) >>> COEF_FRAC)
            + longint'(offset) + longint'(lay) * longint'(step);
        return acc >>> CELL_FRAC;
    endfunction

    function automatic cell_t grid_cell_of(int wx, int wy, byte lay);
        longint cx;
        longint cy;
        cell_t  c;
        cx = axis_cell(cfg_shadow[REG_COEF_XX], cfg_shadow[REG_COEF_XY],
                       cfg_shadow[REG_OFFSET_X], cfg_shadow[REG_LAYER_SHIFT_X], wx, wy, lay);
        cy = axis_cell(cfg_shadow[REG_COEF_YX], cfg_shadow[REG_COEF_YY],
                       cfg_shadow[REG_OFFSET_Y], cfg_shadow[REG_LAYER_SHIFT_Y], wx, wy, lay);
        c = '0;
        if (cx >= 0 && cx < GRID_W && cy >= 0 && cy < GRID_D && lay >= 0 && lay < GRID_H)
        begin
            c.hit = 1'b1;
            c.x   = cx[CX_W-1:0];
            c.y   = cy[CY_W-1:0];
            c.z   = lay[CZ_W-1:0];
        end
        return c;
    endfunction

    function automatic int rand_span(int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_query(int wx, int wy, byte lay);
        query_t q;
        q.wx  = wx;
        q.wy  = wy;
        q.lay = lay;
        pending_queries.push_back(q);
        query_total++;
    endtask

    // checked after the edge has settled so a beat just loaded is not missed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_queries.size() != 0 || in_valid || expected_cells.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < NUM_CFG_REGS)
            cfg_shadow[idx] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(int vals [NUM_CFG_REGS]);
        wait_drained();
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_reg(IDX_W'(i), vals[i]);
    endtask

    // query driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : query_drive
        logic   nv;
        query_t nq;
        int     burst_left;
        int     gap_left;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            world_x    <= '0;
            world_y    <= '0;
            layer      <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            nv = in_valid;
            if (in_valid && !in_stall)
            begin
                expected_cells.push_back(grid_cell_of(world_x, world_y, layer));
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_queries.size() != 0)
                begin
                    nq = pending_queries.pop_front();
                    nv = 1'b1;
                    world_x <= nq.wx;
                    world_y <= nq.wy;
                    layer   <= nq.lay;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            in_valid <= nv;
        end
    end

    // result side stall: changing modes plus requested long holds
    always @(posedge clk or negedge rst_n)
    begin : result_stall
        logic ns;
        int   hold_served;
        int   hold_left;
        int   stall_mode;
        int   mode_left;
        int   pat_cnt;
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_served = 0;
            hold_left   = 0;
            stall_mode  = 0;
            mode_left   = 0;
            pat_cnt     = 0;
        end
        else
        begin
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            else
                mode_left--;
            pat_cnt++;
            if (hold_left > 0)
            begin
                hold_left--;
                ns = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: ns = 1'b0;
                    1: ns = ($urandom_range(0, 3) == 0);
                    2: ns = (pat_cnt % 3 == 2);
                    default: ns = ($urandom_range(0, 9) < 7);
                endcase
            end
            out_stall <= ns;
        end
    end

    always @(posedge clk)
    begin : result_check
        cell_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("result beat with no query outstanding: hit=%0d x=%0d y=%0d z=%0d",
                       hit, cell_x, cell_y, cell_z);
                mismatch_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("hit", want.hit, hit);
                check_field("cell_x", want.x, cell_x);
                check_field("cell_y", want.y, cell_y);
                check_field("cell_z", want.z, cell_z);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int stuck_cycles;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (pending_queries.size() == 0 && !in_valid && expected_cells.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int vals [NUM_CFG_REGS];
        int style;
        int chunk;
        int pause_at;
        int phase_no;

        foreach (cfg_shadow[i])
            cfg_shadow[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: every cell is zero, only the layer decides
        queue_query(0, 0, 0);
        queue_query(WORD_MAX, WORD_MIN, 15);
        queue_query(WORD_MIN, WORD_MAX, 16);
        queue_query(0, 0, -1);
        queue_query(0, 0, 127);
        queue_query(0, 0, -128);

        // identity mapping: world units are cells
        vals = '{default: 0};
        vals[REG_COEF_XX] = ONE_COEF;
        vals[REG_COEF_YY] = ONE_COEF;
        program_regs(vals);
        queue_query(0, 0, 0);
        queue_query(64 * ONE_CELL - 1, 64 * ONE_CELL - 1, 15);
        queue_query(64 * ONE_CELL, 0, 0);
        queue_query(0, 64 * ONE_CELL, 0);
        queue_query(-1, 5 * ONE_CELL, 3);
        queue_query(5 * ONE_CELL, -1, 3);
        queue_query(ONE_CELL, ONE_CELL, 16);
        queue_query(ONE_CELL, ONE_CELL, -1);
        queue_query(WORD_MAX, WORD_MIN, 127);
        queue_query(WORD_MIN, WORD_MAX, -128);

        // skewed axes with offsets and per-layer shifts
        vals[REG_COEF_XY]       = ONE_COEF / 2;
        vals[REG_COEF_YX]       = -(ONE_COEF / 4);
        vals[REG_OFFSET_X]      = 10 * ONE_CELL + ONE_CELL / 2;
        vals[REG_OFFSET_Y]      = -3 * ONE_CELL;
        vals[REG_LAYER_SHIFT_X] = 2 * ONE_CELL;
        vals[REG_LAYER_SHIFT_Y] = -(ONE_CELL + ONE_CELL / 2);
        program_regs(vals);
        queue_query(3 * ONE_CELL, 40 * ONE_CELL, 0);
        queue_query(-5 * ONE_CELL + 7, 50 * ONE_CELL, 7);
        queue_query(ONE_CELL / 3, 60 * ONE_CELL, 15);
        queue_query(20 * ONE_CELL, 30 * ONE_CELL, 12);

        // writes past the register list must leave the mapping alone
        wait_drained();
        write_reg(IDX_W'(NUM_CFG_REGS), WORD_MAX);
        write_reg({IDX_W{1'b1}}, WORD_MIN);
        queue_query(3 * ONE_CELL, 40 * ONE_CELL, 0);

        // widest sums: all registers at the top, then at the bottom
        vals = '{default: WORD_MAX};
        program_regs(vals);
        queue_query(WORD_MAX, WORD_MIN, 127);
        queue_query(WORD_MIN, WORD_MIN, -128);
        queue_query(-1, 1, 1);
        vals = '{default: WORD_MIN};
        program_regs(vals);
        queue_query(WORD_MAX, WORD_MAX, 127);
        queue_query(WORD_MIN, WORD_MAX, -128);

        phase_no = 0;
        while (query_total < TARGET_QUERIES)
        begin
            style = $urandom_range(0, 9);
            foreach (vals[i])
            begin
                if (style < 7)
                    vals[i] = rand_span(ONE_COEF);
                else if (style == 7)
                    vals[i] = int'($urandom);
                else
                    vals[i] = pick_extreme();
            end
            if (style < 7)
            begin
                vals[REG_OFFSET_X]      = $urandom_range(16 * ONE_CELL, 48 * ONE_CELL);
                vals[REG_OFFSET_Y]      = $urandom_range(16 * ONE_CELL, 48 * ONE_CELL);
                vals[REG_LAYER_SHIFT_X] = rand_span(2 * ONE_CELL);
                vals[REG_LAYER_SHIFT_Y] = rand_span(2 * ONE_CELL);
            end
            program_regs(vals);

            chunk = $urandom_range(60, 200);
            pause_at = (phase_no == 1 || $urandom_range(0, 5) == 0) ? chunk / 2 : chunk;
            for (int k = 0; k < chunk; k++)
            begin
                // sender waits for every outstanding result before going on
                if (k == pause_at)
                    wait_drained();
                if (style < 7 && $urandom_range(0, 4) != 0)
                    queue_query(rand_span(40 * ONE_CELL), rand_span(40 * ONE_CELL),
                                byte'(($urandom_range(0, 6) != 0)
                                      ? $urandom_range(0, GRID_H - 1)
                                      : $urandom_range(0, 255)));
                else
                    queue_query(int'($urandom), int'($urandom),
                                byte'($urandom_range(0, 255)));
            end
            // long result-side hold while the queue is still full
            if (phase_no == 0 || $urandom_range(0, 5) == 0)
                hold_requests <= hold_requests + 1;
            phase_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
